FILE: sv/wlc_pkg.sv
// shared types, codes and defaults for the write-back lru cache tag block
`default_nettype none

package wlc_pkg;

    // fixed field widths of the item channels
    localparam int ADDR_W     = 32;
    localparam int WAY_USED_W = 3;

    // default geometry
    localparam int SETS_DEF        = 64;
    localparam int WAYS_DEF        = 8;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;     // write reset metadata at the sweep row
        logic accept;     // capture a new item
        logic rd_input;   // read the set taken straight from the input address
        logic rd_split;   // read the set produced by the divider
        logic commit;     // write back metadata, load the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is at the last row
        logic div_done;   // set and tag split finished
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/wlc_if.sv
// item channel interfaces: access request and lookup result
`default_nettype none

interface wlc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        is_store;

    modport source (output valid, output address, output is_store, input ready);
    modport sink   (input valid, input address, input is_store, output ready);
endinterface

interface wlc_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       ld_miss;
    logic       st_miss;
    logic       writeback;
    logic [2:0] way_used;

    modport source (output valid, output hit, output ld_miss, output st_miss,
                    output writeback, output way_used, input ready);
    modport sink   (input valid, input hit, input ld_miss, input st_miss,
                    input writeback, input way_used, output ready);
endinterface

`default_nettype wire

FILE: sv/writeback_lru_cache_tags_core.sv
// top level: set-associative write-back cache tags with true lru replacement
// an accepted item's set and tag come from the address by wiring (power-of-two SETS) or
//   from the reciprocal set/tag split; then the tag/metadata row is read and the commit
//   writes that row back and loads the result register; one item at a time, the next is
//   accepted only after that commit, and a stalled result holds the next item
// reset: clears control state; a sweep over all SETS rows clears valid/dirty, resets ranks
`default_nettype none

module writeback_lru_cache_tags_core #(
    parameter int SETS        = wlc_pkg::SETS_DEF,
    parameter int WAYS        = wlc_pkg::WAYS_DEF,
    parameter int OFFSET_BITS = wlc_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = wlc_pkg::ADDR_BITS_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    wlc_req_if.sink   req,
    wlc_rsp_if.source rsp
);
    import wlc_pkg::*;

    // a power-of-two set count splits the address by wiring alone
    localparam bit FAST_SPLIT = ((SETS & (SETS - 1)) == 0);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing: sweep, accept, optional divide, lookup and commit
    wlc_ctrl #(
        .FAST_SPLIT (FAST_SPLIT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // tag/metadata memories and the per-way compare, victim and lru update
    wlc_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .FAST_SPLIT  (FAST_SPLIT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .address    (req.address),
        .is_store   (req.is_store),
        .hit        (rsp.hit),
        .ld_miss    (rsp.ld_miss),
        .st_miss    (rsp.st_miss),
        .writeback  (rsp.writeback),
        .way_used   (rsp.way_used)
    );

    // a commit never overwrites a result that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("commit over a stalled result");

    // a result appears only after a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // one item at a time: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("back-to-back accept");

    // every result is exactly one of hit, load miss, store miss
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ($countones({rsp.hit, rsp.ld_miss, rsp.st_miss}) == 1))
        else $error("result flags inconsistent");

    // no writeback on a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> !rsp.writeback)
        else $error("writeback on a hit");

endmodule

`default_nettype wire

FILE: sv/wlc_ctrl.sv
// controller state machine: clearing sweep, accept, split, lookup and commit
`default_nettype none

module wlc_ctrl #(
    parameter bit FAST_SPLIT = 1'b1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire                    rsp_ready,
    output wlc_pkg::dp_cmd_t       cmd,
    input  wlc_pkg::dp_status_t    status
);
    import wlc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = FAST_SPLIT ? ST_LOOKUP : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.accept   = req_valid;
                cmd.rd_input = req_valid && FAST_SPLIT;
            end
            ST_DIVIDE:
            begin
                cmd.rd_split = status.div_done;
            end
            ST_LOOKUP:
            begin
                cmd.commit = slot_free;
            end
            default: cmd = '0;
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/wlc_dp.sv
// datapath: address split, tag and metadata memories, hit and victim logic
`default_nettype none

module wlc_dp #(
    parameter int SETS        = wlc_pkg::SETS_DEF,
    parameter int WAYS        = wlc_pkg::WAYS_DEF,
    parameter int OFFSET_BITS = wlc_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = wlc_pkg::ADDR_BITS_DEF,
    parameter bit FAST_SPLIT  = 1'b1
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wlc_pkg::dp_cmd_t                   cmd,
    output wlc_pkg::dp_status_t                status,
    input  wire  [wlc_pkg::ADDR_W-1:0]         address,
    input  wire                                is_store,
    output logic                               hit,
    output logic                               ld_miss,
    output logic                               st_miss,
    output logic                               writeback,
    output logic [wlc_pkg::WAY_USED_W-1:0]     way_used
);
    import wlc_pkg::*;

    localparam int AW_EFF    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int BLOCK_W   = AW_EFF - OFFSET_BITS;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int FLOOR_LG  = $clog2(SETS + 1) - 1;
    localparam int TAG_W     = (BLOCK_W - FLOOR_LG > 0) ? (BLOCK_W - FLOOR_LG) : 1;
    localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [BLOCK_W-1:0] block;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               store_reg;
    logic [SET_W-1:0]   clr_cnt_reg;
    logic [SET_W-1:0]   rd_addr;
    logic [SET_W-1:0]   fast_set;
    logic [TAG_W-1:0]   fast_tag;
    logic [SET_W-1:0]   split_set;
    logic [TAG_W-1:0]   split_tag;

    assign block = address[AW_EFF-1:OFFSET_BITS];

    // clearing sweep over the metadata rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_wr && !status.clr_last)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    assign status.clr_last = (clr_cnt_reg == SET_W'(SETS - 1));

    // set and tag split
    generate
        if (FAST_SPLIT)
        begin : g_shift_split
            localparam int LOG2S = $clog2(SETS);
            logic [ADDR_W-1:0] block_wide;

            assign block_wide      = ADDR_W'(block);
            assign fast_set        = (SETS == 1) ? '0 : SET_W'(block);
            assign fast_tag        = TAG_W'(block_wide >> LOG2S);
            assign split_set       = fast_set;
            assign split_tag       = fast_tag;
            assign status.div_done = 1'b0;
        end
        else
        begin : g_div_split
            // quotient by reciprocal multiply, then remainder by multiply and subtract
            localparam int LG_S      = $clog2(SETS);
            localparam int SHIFT     = BLOCK_W + LG_S;
            localparam int RECIP_W   = BLOCK_W + 1;
            localparam int PROD_W    = BLOCK_W + RECIP_W;
            localparam int DIV_STEPS = 2;
            localparam logic [RECIP_W-1:0] RECIP =
                RECIP_W'(((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));

            logic [BLOCK_W-1:0] blk_reg;
            logic [BLOCK_W-1:0] quot_reg;
            logic [SET_W-1:0]   rem_reg;
            logic [1:0]         step_reg;
            logic [PROD_W-1:0]  prod;
            logic [BLOCK_W-1:0] quot_next;
            logic [BLOCK_W-1:0] back_mul;
            logic [BLOCK_W-1:0] rem_full;

            assign prod      = PROD_W'(blk_reg) * PROD_W'(RECIP);
            assign quot_next = BLOCK_W'(prod >> SHIFT);
            assign back_mul  = BLOCK_W'(quot_reg * BLOCK_W'(SETS));
            assign rem_full  = blk_reg - back_mul;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    step_reg <= '0;
                else if (cmd.accept)
                    step_reg <= 2'(DIV_STEPS);
                else if (step_reg != '0)
                    step_reg <= step_reg - 1'b1;
            end

            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                    blk_reg <= block;
                // first step: quotient
                if (step_reg == 2'(DIV_STEPS))
                    quot_reg <= quot_next;
                // second step: remainder
                if (step_reg == 2'd1)
                    rem_reg <= SET_W'(rem_full);
            end

            assign fast_set        = '0;
            assign fast_tag        = '0;
            assign split_set       = rem_reg;
            assign split_tag       = TAG_W'(quot_reg);
            assign status.div_done = (step_reg == '0);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            store_reg <= is_store;
        if (cmd.rd_input)
        begin
            set_reg <= fast_set;
            tag_reg <= fast_tag;
        end
        else if (cmd.rd_split)
        begin
            set_reg <= split_set;
            tag_reg <= split_tag;
        end
    end

    assign rd_addr = cmd.rd_input ? fast_set : split_set;

    // memories, one row per set, registered read data
    logic [WAYS-1:0][TAG_W-1:0]  tag_mem   [SETS];
    logic [WAYS-1:0]             valid_mem [SETS];
    logic [WAYS-1:0]             dirty_mem [SETS];
    logic [WAYS-1:0][RANK_W-1:0] rank_mem  [SETS];

    logic [WAYS-1:0][TAG_W-1:0]  tag_q;
    logic [WAYS-1:0]             valid_q, dirty_q;
    logic [WAYS-1:0][RANK_W-1:0] rank_q;

    logic [WAYS-1:0][TAG_W-1:0]  tag_new;
    logic [WAYS-1:0]             valid_new, dirty_new;
    logic [WAYS-1:0][RANK_W-1:0] rank_new;
    logic [WAYS-1:0][RANK_W-1:0] rank_init;

    logic                        meta_we, tag_we;
    logic [SET_W-1:0]            wr_addr;
    logic [WAYS-1:0]             meta_valid_wd, meta_dirty_wd;
    logic [WAYS-1:0][RANK_W-1:0] meta_rank_wd;

    logic [RANK_W-1:0] hit_way, inv_way, lru_way, victim;
    logic              any_hit, any_inv;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
            rank_init[w] = RANK_W'(w);
    end

    assign meta_we       = cmd.clr_wr || cmd.commit;
    assign tag_we        = cmd.commit && !any_hit;
    assign wr_addr       = cmd.clr_wr ? clr_cnt_reg : set_reg;
    assign meta_valid_wd = cmd.clr_wr ? '0 : valid_new;
    assign meta_dirty_wd = cmd.clr_wr ? '0 : dirty_new;
    assign meta_rank_wd  = cmd.clr_wr ? rank_init : rank_new;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            valid_mem[wr_addr] <= meta_valid_wd;
            dirty_mem[wr_addr] <= meta_dirty_wd;
            rank_mem[wr_addr]  <= meta_rank_wd;
        end
        if (cmd.rd_input || cmd.rd_split)
        begin
            valid_q <= valid_mem[rd_addr];
            dirty_q <= dirty_mem[rd_addr];
            rank_q  <= rank_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[set_reg] <= tag_new;
        if (cmd.rd_input || cmd.rd_split)
            tag_q <= tag_mem[rd_addr];
    end

    // hit detection and victim choice
    always_comb
    begin
        any_hit = 1'b0;
        any_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_q[w] && (tag_q[w] == tag_reg))
            begin
                any_hit = 1'b1;
                hit_way = RANK_W'(w);
            end
            if (!valid_q[w])
            begin
                any_inv = 1'b1;
                inv_way = RANK_W'(w);
            end
            if (rank_q[w] == RANK_W'(WAYS - 1))
                lru_way = RANK_W'(w);
        end
        if (any_hit)
            victim = hit_way;
        else if (any_inv)
            victim = inv_way;
        else
            victim = lru_way;
    end

    // updated row
    always_comb
    begin
        valid_new = valid_q;
        dirty_new = dirty_q;
        tag_new   = tag_q;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rank_q[w] < rank_q[victim])
                rank_new[w] = rank_q[w] + 1'b1;
            else
                rank_new[w] = rank_q[w];
        end
        rank_new[victim]  = '0;
        valid_new[victim] = 1'b1;
        tag_new[victim]   = tag_reg;
        if (any_hit)
            dirty_new[victim] = dirty_q[victim] | store_reg;
        else
            dirty_new[victim] = store_reg;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit       <= any_hit;
            ld_miss   <= !any_hit && !store_reg;
            st_miss   <= !any_hit && store_reg;
            writeback <= !any_hit && valid_q[victim] && dirty_q[victim];
            way_used  <= WAY_USED_W'(victim);
        end
    end

endmodule

`default_nettype wire
